### design/mexp_pkg.sv
// ----------------------------------------------------------------------------
// mexp_pkg
// Shared constants, control word types and the sequencer program for the
// modular exponentiation block.
// ----------------------------------------------------------------------------
package mexp_pkg;

    // Default data width
    localparam int unsigned WIDTH_DEF = 32;

    // Program counter width
    localparam int unsigned PC_W = 4;

    // Branch conditions: branch taken jumps to target, else step on
    typedef enum logic [2:0] {
        C_NONE,
        C_ALWAYS,
        C_NO_INPUT,
        C_MOD_SMALL,
        C_EBIT_ZERO,
        C_MUL_BUSY,
        C_MORE_BITS,
        C_OUT_FULL
    } t_cond;

    // Datapath actions, one per step
    typedef enum logic [3:0] {
        A_NONE,
        A_LOAD,
        A_RED_START,
        A_MUL_START,
        A_SQR_START,
        A_WR_B,
        A_WR_ACC,
        A_NEXT_BIT,
        A_EMIT,
        A_CLR_ACC
    } t_act;

    typedef struct packed {
        t_act              act;
        t_cond             cond;
        logic [PC_W-1:0]   target;
    } t_uword;

    // Step addresses used as jump targets
    localparam logic [PC_W-1:0] S_IDLE   = 4'd0;
    localparam logic [PC_W-1:0] S_REDW   = 4'd3;
    localparam logic [PC_W-1:0] S_TEST   = 4'd4;
    localparam logic [PC_W-1:0] S_MULW   = 4'd6;
    localparam logic [PC_W-1:0] S_SQR    = 4'd7;
    localparam logic [PC_W-1:0] S_SQRW   = 4'd8;
    localparam logic [PC_W-1:0] S_EMIT   = 4'd10;
    localparam logic [PC_W-1:0] S_ZERO   = 4'd12;

    // Sequencer program (read-only)
    function automatic t_uword uprog(input logic [PC_W-1:0] pc);
        t_uword w;
        unique case (pc)
            4'd0:    w = '{act: A_LOAD,      cond: C_NO_INPUT,  target: S_IDLE};
            4'd1:    w = '{act: A_NONE,      cond: C_MOD_SMALL, target: S_ZERO};
            4'd2:    w = '{act: A_RED_START, cond: C_NONE,      target: S_IDLE};
            4'd3:    w = '{act: A_WR_B,      cond: C_MUL_BUSY,  target: S_REDW};
            4'd4:    w = '{act: A_NONE,      cond: C_EBIT_ZERO, target: S_SQR};
            4'd5:    w = '{act: A_MUL_START, cond: C_NONE,      target: S_IDLE};
            4'd6:    w = '{act: A_WR_ACC,    cond: C_MUL_BUSY,  target: S_MULW};
            4'd7:    w = '{act: A_SQR_START, cond: C_NONE,      target: S_IDLE};
            4'd8:    w = '{act: A_WR_B,      cond: C_MUL_BUSY,  target: S_SQRW};
            4'd9:    w = '{act: A_NEXT_BIT,  cond: C_MORE_BITS, target: S_TEST};
            4'd10:   w = '{act: A_EMIT,      cond: C_OUT_FULL,  target: S_EMIT};
            4'd11:   w = '{act: A_NONE,      cond: C_ALWAYS,    target: S_IDLE};
            4'd12:   w = '{act: A_CLR_ACC,   cond: C_ALWAYS,    target: S_EMIT};
            default: w = '{act: A_NONE,      cond: C_ALWAYS,    target: S_IDLE};
        endcase
        return w;
    endfunction

endpackage

### design/mexp_mulmod.sv
// ----------------------------------------------------------------------------
// mexp_mulmod
// Bit-serial modular multiplier: (a * bits) mod m, one bit of the
// multiplier per cycle from the top, double then conditional add.
// ----------------------------------------------------------------------------
module mexp_mulmod import mexp_pkg::*; #(
    parameter int unsigned WIDTH = WIDTH_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [WIDTH-1:0] i_a,
    input  logic [WIDTH-1:0] i_bits,
    input  logic [WIDTH-1:0] i_m,
    output logic             o_busy,
    output logic [WIDTH-1:0] o_result
);

    localparam int unsigned KW = $clog2(WIDTH);
    localparam logic [KW-1:0] K_LAST = KW'(WIDTH - 1);

    logic             r_busy;
    logic [KW-1:0]    r_cnt;
    logic [WIDTH-1:0] r_acc, r_a, r_bits;
    logic [WIDTH:0]   dbl, red1, sum, red2, m_ext;

    // One step: acc = 2*acc mod m, then + a mod m when the bit is set
    always_comb begin
        m_ext = {1'b0, i_m};
        dbl   = {r_acc, 1'b0};
        red1  = (dbl >= m_ext) ? (dbl - m_ext) : dbl;
        sum   = red1 + {1'b0, (r_bits[WIDTH-1] ? r_a : '0)};
        red2  = (sum >= m_ext) ? (sum - m_ext) : sum;
    end

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_start) begin
            r_busy <= 1'b1;
        end else if (r_busy && r_cnt == K_LAST) begin
            r_busy <= 1'b0;
        end
    end

    // Operands and accumulator
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_acc  <= '0;
            r_a    <= i_a;
            r_bits <= i_bits;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_acc  <= red2[WIDTH-1:0];
            r_bits <= {r_bits[WIDTH-2:0], 1'b0};
            r_cnt  <= r_cnt + 1'b1;
        end
    end

    assign o_busy   = r_busy;
    assign o_result = r_acc;

endmodule

### design/modular_exponentiation.sv
// Each item runs right to left through the exponent: base reduction, then a square per
// exponent bit and a further product per set bit, all on the bit-serial multiplier;
// a modulus below 2 skips straight to a zero result.
// One item at a time: the next input beat is taken only after the result is queued.
// Reset: synchronous active low; modulus returns to 2, sequencer to idle, output empty.
// ----------------------------------------------------------------------------
// modular_exponentiation
// Right-to-left square-and-multiply under control of a small microprogram,
// sharing one bit-serial modular multiplier for reduction and products.
// ----------------------------------------------------------------------------
module modular_exponentiation import mexp_pkg::*; #(
    parameter int unsigned WIDTH = WIDTH_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [WIDTH-1:0] i_cfg_data,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  logic [WIDTH-1:0] i_base,
    input  logic [WIDTH-1:0] i_exponent,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output logic [WIDTH-1:0] o_power_mod
);

    localparam int unsigned KW = $clog2(WIDTH);
    localparam logic [KW-1:0] K_LAST = KW'(WIDTH - 1);

    logic [PC_W-1:0]  r_pc, n_pc;
    logic [WIDTH-1:0] r_mod;
    logic [WIDTH-1:0] r_base, r_b, r_exp, r_acc, r_power_mod;
    logic [KW-1:0]    r_k;
    logic             r_out_valid;
    t_uword           uw;
    logic             taken;
    logic             mul_start, mul_busy;
    logic [WIDTH-1:0] mul_a, mul_bits, mul_res;
    logic             out_full;

    // Fetch and branch
    assign uw       = uprog(r_pc);
    assign out_full = r_out_valid && !i_out_ready;

    always_comb begin
        unique case (uw.cond)
            C_NONE:      taken = 1'b0;
            C_ALWAYS:    taken = 1'b1;
            C_NO_INPUT:  taken = !i_in_valid;
            C_MOD_SMALL: taken = (r_mod < WIDTH'(2));
            C_EBIT_ZERO: taken = !r_exp[0];
            C_MUL_BUSY:  taken = mul_busy;
            C_MORE_BITS: taken = (r_k != K_LAST);
            C_OUT_FULL:  taken = out_full;
            default:     taken = 1'b1;
        endcase
        n_pc = taken ? uw.target : r_pc + 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= S_IDLE;
        end else begin
            r_pc <= n_pc;
        end
    end

    // Configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mod <= WIDTH'(2);
        end else if (i_cfg_we) begin
            r_mod <= i_cfg_data;
        end
    end

    // Multiplier operand selection
    always_comb begin
        mul_start = 1'b0;
        mul_a     = r_b;
        mul_bits  = r_b;
        unique case (uw.act)
            A_RED_START: begin
                mul_start = 1'b1;
                mul_a     = WIDTH'(1);
                mul_bits  = r_base;
            end
            A_MUL_START: begin
                mul_start = 1'b1;
                mul_a     = r_acc;
            end
            A_SQR_START: begin
                mul_start = 1'b1;
            end
            default: begin
                mul_start = 1'b0;
            end
        endcase
    end

    mexp_mulmod #(
        .WIDTH (WIDTH)
    ) u_mulmod (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (mul_start),
        .i_a      (mul_a),
        .i_bits   (mul_bits),
        .i_m      (r_mod),
        .o_busy   (mul_busy),
        .o_result (mul_res)
    );

    // Working registers
    always_ff @(posedge i_clk) begin
        unique case (uw.act)
            A_LOAD: begin
                if (i_in_valid) begin
                    r_base <= i_base;
                    r_b    <= i_base;
                    r_exp  <= i_exponent;
                    r_acc  <= WIDTH'(1);
                    r_k    <= '0;
                end
            end
            A_WR_B: begin
                if (!mul_busy) begin
                    r_b <= mul_res;
                end
            end
            A_WR_ACC: begin
                if (!mul_busy) begin
                    r_acc <= mul_res;
                end
            end
            A_NEXT_BIT: begin
                r_exp <= r_exp >> 1;
                r_k   <= r_k + 1'b1;
            end
            A_CLR_ACC: begin
                r_acc <= '0;
            end
            default: begin
            end
        endcase
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (uw.act == A_EMIT && !out_full) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (uw.act == A_EMIT && !out_full) begin
            r_power_mod <= r_acc;
        end
    end

    assign o_in_ready  = (uw.act == A_LOAD);
    assign o_out_valid = r_out_valid;
    assign o_power_mod = r_power_mod;

endmodule

### dv/mexp_checker.sv
// ----------------------------------------------------------------------------
// mexp_checker
// Passive checker for the modular exponentiation block. It follows modulus
// writes, predicts each power with exact wide arithmetic and compares every
// result beat with the oldest prediction still waiting.
// ----------------------------------------------------------------------------
module mexp_checker #(
    parameter int unsigned WIDTH = 32
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [WIDTH-1:0] i_cfg_data,
    input  logic             i_in_valid,
    input  logic             i_in_ready,
    input  logic [WIDTH-1:0] i_base,
    input  logic [WIDTH-1:0] i_exponent,
    input  logic             i_out_valid,
    input  logic             i_out_ready,
    input  logic [WIDTH-1:0] i_power_mod,
    output int               o_fail_count,
    output int               o_pending,
    output int               o_checked
);

    typedef logic [WIDTH-1:0]   t_word;
    typedef logic [2*WIDTH-1:0] t_wide;

    t_word modulus_copy = t_word'(2);
    t_word power_q[$];
    int    fail_count = 0;
    int    pending    = 0;
    int    checked    = 0;

    assign o_fail_count = fail_count;
    assign o_pending    = pending;
    assign o_checked    = checked;

    // Right-to-left square-and-multiply; operands stay below the modulus,
    // so a double-width product never overflows
    function automatic t_word predict_power(input t_word m, input t_word b, input t_word e);
        t_wide acc;
        t_wide sq;
        t_wide mw;
        if (m < t_word'(2)) return '0;
        mw  = t_wide'(m);
        acc = t_wide'(1);
        sq  = t_wide'(b) % mw;
        for (int k = 0; k < WIDTH; k++) begin
            if (e[k]) acc = (acc * sq) % mw;
            sq = (sq * sq) % mw;
        end
        return t_word'(acc);
    endfunction

    // One line per mismatch, and count it
    task automatic report_mismatch(input string what, input t_word want, input t_word got);
        fail_count++;
        $display("[%0t] mismatch: %s (expected %h, got %h)", $time, what, want, got);
    endtask

    // Track modulus, queue predictions, compare result beats
    always @(posedge i_clk) begin
        t_word want;
        if (!i_rst_n) begin
            modulus_copy = t_word'(2);
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (power_q.size() == 0) begin
                    report_mismatch("result beat with nothing expected", '0, i_power_mod);
                end else begin
                    want = power_q.pop_front();
                    checked++;
                    if (want !== i_power_mod) begin
                        report_mismatch("power_mod", want, i_power_mod);
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                power_q.push_back(predict_power(modulus_copy, i_base, i_exponent));
            end
            if (i_cfg_we) begin
                modulus_copy = i_cfg_data;
            end
        end
        pending = power_q.size();
    end

endmodule

### dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the modular exponentiation block: directed corner
// items, then random phases under several moduli, with random gaps on the
// input side and random stalls on the result side.
// ----------------------------------------------------------------------------
module tb_top;
    import mexp_pkg::WIDTH_DEF;

    localparam int unsigned W = WIDTH_DEF;
    typedef logic [W-1:0] t_word;

    logic  i_clk;
    logic  i_rst_n     = 1'b0;
    logic  i_cfg_we    = 1'b0;
    t_word i_cfg_data  = '0;
    logic  i_in_valid  = 1'b0;
    t_word i_base      = '0;
    t_word i_exponent  = '0;
    logic  i_out_ready = 1'b0;
    logic  o_in_ready;
    logic  o_out_valid;
    t_word o_power_mod;

    int    fail_count;
    int    pending;
    int    checked;

    t_word modulus_now   = t_word'(2);
    bit    quiet         = 1'b0;
    int    items_sent    = 0;
    int    settings_used = 1;
    int    stall_left    = 0;

    modular_exponentiation #(
        .WIDTH(W)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_base     (i_base),
        .i_exponent (i_exponent),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_power_mod(o_power_mod)
    );

    mexp_checker #(
        .WIDTH(W)
    ) u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .i_in_ready  (o_in_ready),
        .i_base      (i_base),
        .i_exponent  (i_exponent),
        .i_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_power_mod (o_power_mod),
        .o_fail_count(fail_count),
        .o_pending   (pending),
        .o_checked   (checked)
    );

    // Clock, period 2
    always begin
        i_clk = 1'b1;
        #1;
        i_clk = 1'b0;
        #1;
    end

    // Mostly short gaps, now and then a long one
    function automatic int pick_gap();
        if ($urandom_range(0, 9) < 8) return $urandom_range(0, 3);
        return $urandom_range(10, 150);
    endfunction

    // Result side back-pressure
    always @(negedge i_clk) begin
        if (quiet) begin
            i_out_ready <= 1'b1;
            stall_left  <= 0;
        end else if (stall_left > 0) begin
            i_out_ready <= 1'b0;
            stall_left  <= stall_left - 1;
        end else begin
            i_out_ready <= 1'b1;
            if ($urandom_range(0, 7) == 0) stall_left <= pick_gap();
        end
    end

    // One input beat: optional gap, then hold until accepted
    task automatic send_item(input t_word b, input t_word e);
        int gap;
        gap = quiet ? 0 : pick_gap();
        @(negedge i_clk);
        if (gap > 0) begin
            i_in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_base     = b;
        i_exponent = e;
        i_in_valid = 1'b1;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        items_sent++;
    endtask

    // Stop sending and wait for every outstanding result
    task automatic wait_idle();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (pending != 0) @(negedge i_clk);
    endtask

    // Modulus write, only once the block has gone quiet
    task automatic write_modulus(input t_word m);
        wait_idle();
        @(negedge i_clk);
        i_cfg_data = m;
        i_cfg_we   = 1'b1;
        @(negedge i_clk);
        i_cfg_we    = 1'b0;
        modulus_now = m;
        settings_used++;
    endtask

    // Random item, biased towards edge values of base and exponent
    task automatic send_random();
        t_word b;
        t_word e;
        case ($urandom_range(0, 9))
            0:       b = '0;
            1:       b = '1;
            2:       b = modulus_now + t_word'($urandom_range(0, 3));
            3:       b = modulus_now - t_word'(1);
            default: b = t_word'($urandom);
        endcase
        case ($urandom_range(0, 9))
            0:       e = '0;
            1:       e = '1;
            2:       e = t_word'($urandom_range(0, 15));
            default: e = t_word'($urandom);
        endcase
        send_item(b, e);
    endtask

    // Stimulus
    initial begin
        repeat (8) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Reset modulus of two
        send_item('0, '0);
        send_item(t_word'(1), t_word'(1));
        send_item('1, '1);
        send_item(t_word'(3), t_word'(5));

        // Full-width composite modulus, base at and below it
        write_modulus('1);
        send_item('1, t_word'(1));
        send_item('0, '0);
        send_item('1 - t_word'(1), '1);
        send_item(t_word'(2), t_word'(32));

        // Large prime, base equal to the modulus, zero exponent
        write_modulus(t_word'(32'hFFFF_FFFB));
        send_item('1, '1);
        send_item(t_word'(5), '0);
        send_item(t_word'(32'hFFFF_FFFB), t_word'(3));
        send_item(t_word'(32'h1234_5678), t_word'(32'hFFFF_FFFA));

        // Modulus of one, then of zero: everything reduces to zero
        write_modulus(t_word'(1));
        send_item(t_word'(7), '0);
        send_item('1, '1);
        write_modulus('0);
        send_item('0, '0);
        send_item(t_word'(5), t_word'(3));

        // Random phases, one modulus each
        for (int phase = 0; phase < 9; phase++) begin
            t_word m;
            case (phase)
                0:       m = t_word'(32'hFFFF_FFFB);
                1:       m = t_word'($urandom_range(2, 300));
                2:       m = t_word'($urandom) | t_word'(32'h8000_0000);
                3:       m = '1;
                5:       m = t_word'(3);
                6:       m = t_word'($urandom_range(2, 65535));
                8:       m = t_word'(2);
                default: m = t_word'($urandom);
            endcase
            write_modulus(m);
            quiet = (phase == 4);
            for (int i = 0; i < 30; i++) begin
                // sender holds off mid-phase until the block has drained
                if (phase == 1 && i == 15) wait_idle();
                send_random();
            end
            quiet = 1'b0;
        end

        wait_idle();
        repeat (2300) @(negedge i_clk);
        $display("Ran %0d items over %0d modulus settings, %0d results compared.",
                 items_sent, settings_used, checked);
        $display("Moduli of zero, one, two, small, prime and full width; exponents zero to max.");
        if (fail_count == 0 && pending == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #10_000_000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
